[design/era_pkg.sv]
package era_pkg;

    localparam int CH_W     = 2;
    localparam int STAMP_W  = 16;
    localparam int DIST_W   = 8;
    localparam int HELD_W   = 3;
    localparam int STEP_W   = $clog2(STAMP_W + 1);

    localparam logic [STAMP_W-1:0] TICKS_RESET = 16'd58;
    localparam logic [DIST_W-1:0]  DIST_SAT    = 8'hFF;

    typedef struct packed {
        logic [CH_W-1:0]    channel;
        logic [STAMP_W-1:0] capture_stamp;
    } in_item_t;

    typedef struct packed {
        logic [CH_W-1:0]    sensor_id;
        logic [STAMP_W-1:0] echo_ticks;
        logic [DIST_W-1:0]  distance_cm;
        logic [DIST_W-1:0]  average_cm;
        logic [HELD_W-1:0]  samples_held;
    } out_item_t;

    typedef struct packed {
        logic [STAMP_W-1:0] ticks_per_cm;
    } cfg_word_t;

endpackage

[design/era_chan_if.sv]
interface era_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[design/era_ram.sv]
module era_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

[design/echo_range_moving_average.sv]
// channel   direction  payload                                          transaction
// samples   in         channel, capture_stamp                           one timer edge
// results   out        sensor_id, echo_ticks, distance_cm,              one finished
//                      average_cm, samples_held                         measurement
// cfg       in         ticks_per_cm                                     register write
//
// a rising edge only stores its stamp, and an edge on an unused channel is dropped
// a falling edge divides its width by ticks_per_cm, pushes the window, then divides again,
// using the one-bit-per-cycle restoring divider for distance and then for average
// samples is not ready while a measurement is in flight; cfg is always ready
// a finished result waits in the output register, and the next edge is taken meanwhile
// reset clears all per-channel state; the window memory is never cleared, only used once written
module echo_range_moving_average #(
    parameter int WINDOW_LEN  = 5,
    parameter int NUM_SENSORS = 3
) (
    input  logic       clk,
    input  logic       rst_n,
    era_chan_if.sink   samples,
    era_chan_if.source results,
    era_chan_if.sink   cfg
);
    import era_pkg::*;

    localparam int SLOT_W   = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int FILL_W   = $clog2(WINDOW_LEN + 1);
    localparam int TOT_W    = DIST_W + FILL_W;
    localparam int CH_IDX_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
    localparam int ADDR_W   = CH_IDX_W + SLOT_W;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIST = 3'd1;
    localparam logic [2:0] S_PUSH = 3'd2;
    localparam logic [2:0] S_AVG  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [STAMP_W-1:0]  ticks_per_cm_reg, ticks_per_cm_next;

    // per-channel state
    logic                awaiting_reg [NUM_SENSORS];
    logic                awaiting_next [NUM_SENSORS];
    logic [STAMP_W-1:0]  rise_reg [NUM_SENSORS];
    logic [STAMP_W-1:0]  rise_next [NUM_SENSORS];
    logic [SLOT_W-1:0]   slot_reg [NUM_SENSORS];
    logic [SLOT_W-1:0]   slot_next [NUM_SENSORS];
    logic [FILL_W-1:0]   fill_reg [NUM_SENSORS];
    logic [FILL_W-1:0]   fill_next [NUM_SENSORS];
    logic [TOT_W-1:0]    total_reg [NUM_SENSORS];
    logic [TOT_W-1:0]    total_next [NUM_SENSORS];

    // measurement in flight
    logic [CH_W-1:0]     ch_reg, ch_next;
    logic [STAMP_W-1:0]  ticks_reg, ticks_next;
    logic [DIST_W-1:0]   dist_reg, dist_next;

    // shared restoring divider: remainder, dividend/quotient, divisor, step count
    logic [STAMP_W:0]    rem_reg, rem_next;
    logic [STAMP_W-1:0]  dq_reg, dq_next;
    logic [STAMP_W-1:0]  dvsr_reg, dvsr_next;
    logic [STEP_W-1:0]   step_reg, step_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    out_item_t           out_reg, out_next;

    // combinational helpers
    in_item_t            item;
    logic [CH_IDX_W-1:0] in_idx;
    logic [CH_IDX_W-1:0] cur_idx;
    logic                in_used;
    logic [STAMP_W:0]    rem_shift;
    logic                fits;
    logic [STAMP_W:0]    rem_step;
    logic [STAMP_W-1:0]  dq_step;
    logic [DIST_W-1:0]   dist_sat;
    logic [DIST_W-1:0]   old_sample;
    logic                win_full;
    logic [TOT_W-1:0]    total_push;
    logic [FILL_W-1:0]   fill_push;
    logic [SLOT_W-1:0]   slot_adv;
    logic [ADDR_W-1:0]   win_addr;
    logic                ram_wr_en;
    logic                ram_rd_en;

    assign item    = samples.data;
    assign in_idx  = CH_IDX_W'(item.channel);
    assign cur_idx = CH_IDX_W'(ch_reg);
    assign in_used = (32'(item.channel) < NUM_SENSORS);

    assign samples.ready = (state_reg == S_IDLE);
    assign cfg.ready     = 1'b1;
    assign results.valid = out_valid_reg;
    assign results.data  = out_reg;

    // one divider step: shift in the next dividend bit, subtract if it fits
    // a zero divisor always fits, giving an all-ones quotient that saturates
    assign rem_shift = {rem_reg[STAMP_W-1:0], dq_reg[STAMP_W-1]};
    assign fits      = (rem_shift >= {1'b0, dvsr_reg});
    assign rem_step  = fits ? (rem_shift - {1'b0, dvsr_reg}) : rem_shift;
    assign dq_step   = {dq_reg[STAMP_W-2:0], fits};

    // window push for the channel in flight
    assign dist_sat   = (|dq_reg[STAMP_W-1:DIST_W]) ? DIST_SAT : dq_reg[DIST_W-1:0];
    assign win_full   = (fill_reg[cur_idx] == FILL_W'(WINDOW_LEN));
    assign total_push = win_full
                      ? (total_reg[cur_idx] - TOT_W'(old_sample) + TOT_W'(dist_sat))
                      : (total_reg[cur_idx] + TOT_W'(dist_sat));
    assign fill_push  = win_full ? fill_reg[cur_idx] : (fill_reg[cur_idx] + 1'b1);
    assign slot_adv   = (slot_reg[cur_idx] == SLOT_W'(WINDOW_LEN - 1))
                      ? '0 : (slot_reg[cur_idx] + 1'b1);

    // oldest sample is read during the distance division, overwritten at push
    assign win_addr  = {cur_idx, slot_reg[cur_idx]};
    assign ram_rd_en = (state_reg == S_DIST);
    assign ram_wr_en = (state_reg == S_PUSH);

    era_ram #(
        .WIDTH (DIST_W),
        .DEPTH (1 << ADDR_W)
    ) u_window (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (win_addr),
        .wr_data (dist_sat),
        .rd_en   (ram_rd_en),
        .rd_addr (win_addr),
        .rd_data (old_sample)
    );

    always_comb
    begin
        state_next        = state_reg;
        ticks_per_cm_next = ticks_per_cm_reg;
        awaiting_next     = awaiting_reg;
        rise_next         = rise_reg;
        slot_next         = slot_reg;
        fill_next         = fill_reg;
        total_next        = total_reg;
        ch_next           = ch_reg;
        ticks_next        = ticks_reg;
        dist_next         = dist_reg;
        rem_next          = rem_reg;
        dq_next           = dq_reg;
        dvsr_next         = dvsr_reg;
        step_next         = step_reg;
        out_valid_next    = out_valid_reg;
        out_next          = out_reg;

        if (cfg.valid)
        begin
            ticks_per_cm_next = cfg.data.ticks_per_cm;
        end

        // result taken downstream
        if (results.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (samples.valid && in_used)
                begin
                    if (!awaiting_reg[in_idx])
                    begin
                        // rising edge: remember the stamp
                        rise_next[in_idx]     = item.capture_stamp;
                        awaiting_next[in_idx] = 1'b1;
                    end
                    else
                    begin
                        // falling edge: modular width, start distance division
                        awaiting_next[in_idx] = 1'b0;
                        ch_next    = item.channel;
                        ticks_next = item.capture_stamp - rise_reg[in_idx];
                        rem_next   = '0;
                        dq_next    = item.capture_stamp - rise_reg[in_idx];
                        dvsr_next  = ticks_per_cm_reg;
                        step_next  = STEP_W'(STAMP_W);
                        state_next = S_DIST;
                    end
                end
            end
            S_DIST:
            begin
                rem_next  = rem_step;
                dq_next   = dq_step;
                step_next = step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                dist_next           = dist_sat;
                total_next[cur_idx] = total_push;
                fill_next[cur_idx]  = fill_push;
                slot_next[cur_idx]  = slot_adv;
                // average: total left-aligned so only its TOT_W bits are divided
                rem_next   = '0;
                dq_next    = STAMP_W'(total_push) << (STAMP_W - TOT_W);
                dvsr_next  = STAMP_W'(fill_push);
                step_next  = STEP_W'(TOT_W);
                state_next = S_AVG;
            end
            S_AVG:
            begin
                rem_next  = rem_step;
                dq_next   = dq_step;
                step_next = step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_valid_next        = 1'b1;
                    out_next.sensor_id    = ch_reg;
                    out_next.echo_ticks   = ticks_reg;
                    out_next.distance_cm  = dist_reg;
                    out_next.average_cm   = dq_reg[DIST_W-1:0];
                    out_next.samples_held = HELD_W'(fill_reg[cur_idx]);
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            ticks_per_cm_reg <= TICKS_RESET;
            out_valid_reg    <= 1'b0;
            for (int i = 0; i < NUM_SENSORS; i++)
            begin
                awaiting_reg[i] <= 1'b0;
                rise_reg[i]     <= '0;
                slot_reg[i]     <= '0;
                fill_reg[i]     <= '0;
                total_reg[i]    <= '0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            ticks_per_cm_reg <= ticks_per_cm_next;
            out_valid_reg    <= out_valid_next;
            awaiting_reg     <= awaiting_next;
            rise_reg         <= rise_next;
            slot_reg         <= slot_next;
            fill_reg         <= fill_next;
            total_reg        <= total_next;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        ch_reg    <= ch_next;
        ticks_reg <= ticks_next;
        dist_reg  <= dist_next;
        rem_reg   <= rem_next;
        dq_reg    <= dq_next;
        dvsr_reg  <= dvsr_next;
        step_reg  <= step_next;
        out_reg   <= out_next;
    end
endmodule

[test/echo_range_moving_average_tb.sv]
module echo_range_moving_average_tb;

    import era_pkg::*;

    localparam int WINDOW_LEN    = 5;
    localparam int NUM_SENSORS   = 3;
    // settle time after the last edge, longer than one falling-edge measurement at these sizes
    localparam int SETTLE_CYCLES = 40;
    // longest receiver hold-off, long enough to fill the output register and stall input
    localparam int LONG_HOLD     = 300;
    // cycles with no transaction anywhere before the run is declared hung
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_EDGES  = 140;

    // receiver stall patterns
    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE
    } ready_mode_t;

    logic clk = 1'b0;
    logic rst_n;

    era_chan_if #(.payload_t(in_item_t))  sample_bus ();
    era_chan_if #(.payload_t(out_item_t)) result_bus ();
    era_chan_if #(.payload_t(cfg_word_t)) cfg_bus ();

    echo_range_moving_average #(
        .WINDOW_LEN (WINDOW_LEN),
        .NUM_SENSORS(NUM_SENSORS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .samples(sample_bus),
        .results(result_bus),
        .cfg    (cfg_bus)
    );

    // timer edges waiting to be offered, and measurements waiting to come out
    in_item_t  pending_edges[$];
    out_item_t expected_measurements[$];

    int error_count = 0;
    int quiet_cycles = 0;
    bit samples_fire = 1'b0;
    bit hold_request = 1'b0;
    bit hold_taken = 1'b0;

    // predictor state: one copy of the per-channel ranging state plus the divider
    logic [STAMP_W-1:0] divider_model = TICKS_RESET;
    bit                 fall_pending [NUM_SENSORS] = '{default: 1'b0};
    logic [STAMP_W-1:0] rise_time [NUM_SENSORS] = '{default: '0};
    logic [DIST_W-1:0]  window_cm [NUM_SENSORS][WINDOW_LEN] = '{default: '{default: '0}};
    int unsigned        next_slot [NUM_SENSORS] = '{default: 0};
    int unsigned        held_count [NUM_SENSORS] = '{default: 0};
    int unsigned        window_sum [NUM_SENSORS] = '{default: 0};

    // stimulus-side shadow of the edge polarity, so falling stamps can be aimed
    bit                 gen_fall_next [NUM_SENSORS] = '{default: 1'b0};
    logic [STAMP_W-1:0] gen_rise_time [NUM_SENSORS] = '{default: '0};

    // sender burst state and receiver pattern state
    int          burst_left = 0;
    int          gap_left = 0;
    int          hold_left = 0;
    int          mode_left = 0;
    int unsigned pattern_phase = 0;
    ready_mode_t ready_mode = READY_ALWAYS;

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    // one timer edge: rising edges store the stamp, falling edges finish a measurement
    function automatic void predict_measurement(in_item_t stamp_item);
        int unsigned        ch;
        int unsigned        quotient;
        int unsigned        slot;
        logic [STAMP_W-1:0] ticks;
        out_item_t          m;
        ch = stamp_item.channel;
        // unused channel, nothing changes
        if (ch >= NUM_SENSORS)
            return;
        if (!fall_pending[ch])
        begin
            rise_time[ch] = stamp_item.capture_stamp;
            fall_pending[ch] = 1'b1;
            return;
        end
        fall_pending[ch] = 1'b0;
        // 16-bit context makes this the modular width across a timer wrap
        ticks = stamp_item.capture_stamp - rise_time[ch];
        if (divider_model == '0)
            quotient = 255;
        else
        begin
            quotient = ticks / divider_model;
            if (quotient > 255)
                quotient = 255;
        end
        // full window drops the oldest sample before overwriting it
        slot = next_slot[ch];
        if (held_count[ch] >= WINDOW_LEN)
            window_sum[ch] -= window_cm[ch][slot];
        else
            held_count[ch]++;
        window_cm[ch][slot] = DIST_W'(quotient);
        window_sum[ch] += quotient;
        next_slot[ch] = (slot + 1 == WINDOW_LEN) ? 0 : slot + 1;
        m.sensor_id    = CH_W'(ch);
        m.echo_ticks   = ticks;
        m.distance_cm  = DIST_W'(quotient);
        m.average_cm   = DIST_W'(window_sum[ch] / held_count[ch]);
        m.samples_held = HELD_W'(held_count[ch]);
        expected_measurements.push_back(m);
    endfunction

    // queue one edge and keep the stimulus shadow of the polarity in step
    function automatic void queue_edge(int unsigned ch, logic [STAMP_W-1:0] stamp);
        in_item_t e;
        e.channel = CH_W'(ch);
        e.capture_stamp = stamp;
        pending_edges.push_back(e);
        if (ch < NUM_SENSORS)
        begin
            if (!gen_fall_next[ch])
                gen_rise_time[ch] = stamp;
            gen_fall_next[ch] = !gen_fall_next[ch];
        end
    endfunction

    // mostly aimed pulses that land across the whole distance range,
    // with some raw stamps and some edges on the unused channel
    task automatic queue_random(int count, int unsigned divider);
        int unsigned        ch;
        logic [STAMP_W-1:0] stamp;
        for (int n = 0; n < count; n++)
        begin
            ch = ($urandom_range(0, 15) == 0) ? 3 : $urandom_range(0, NUM_SENSORS - 1);
            if (ch < NUM_SENSORS && gen_fall_next[ch] && $urandom_range(0, 4) != 0)
                stamp = gen_rise_time[ch]
                      + 16'(divider * $urandom_range(0, 300) + $urandom_range(0, divider));
            else
                stamp = 16'($urandom);
            queue_edge(ch, stamp);
        end
    endtask

    // everything offered and every measurement back, then let the divider finish
    task automatic wait_for_idle();
        while (pending_edges.size() != 0 || sample_bus.valid !== 1'b0
               || expected_measurements.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_divider(logic [STAMP_W-1:0] value);
        @(negedge clk);
        cfg_bus.data  <= value;
        cfg_bus.valid <= 1'b1;
        @(posedge clk);
        while (cfg_bus.ready !== 1'b1)
            @(posedge clk);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // sender: bursts of random length with random gaps, new data only at the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            sample_bus.valid <= 1'b0;
            sample_bus.data  <= '0;
        end
        else if (sample_bus.valid !== 1'b1 || samples_fire)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 30);
                gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end
            if (gap_left > 0)
            begin
                gap_left--;
                sample_bus.valid <= 1'b0;
            end
            else if (pending_edges.size() != 0)
            begin
                sample_bus.valid <= 1'b1;
                sample_bus.data  <= pending_edges.pop_front();
                burst_left--;
            end
            else
                sample_bus.valid <= 1'b0;
        end
    end

    // receiver: switches between stall patterns, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_request && !hold_taken)
        begin
            hold_left = LONG_HOLD;
            hold_taken = 1'b1;
        end
        if (!rst_n)
            result_bus.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            result_bus.ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                ready_mode = ready_mode_t'($urandom_range(0, 2));
                mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            pattern_phase++;
            case (ready_mode)
                READY_ALWAYS: result_bus.ready <= 1'b1;
                READY_COIN:   result_bus.ready <= 1'($urandom_range(0, 1));
                default:      result_bus.ready <= (pattern_phase % 4 == 0);
            endcase
        end
    end

    // monitor: every transaction is seen at the rising edge
    always @(posedge clk)
    begin : monitor
        out_item_t got;
        out_item_t want;
        bit        result_fire;
        bit        cfg_fire;
        samples_fire = rst_n && sample_bus.valid === 1'b1 && sample_bus.ready === 1'b1;
        result_fire  = rst_n && result_bus.valid === 1'b1 && result_bus.ready === 1'b1;
        cfg_fire     = rst_n && cfg_bus.valid === 1'b1 && cfg_bus.ready === 1'b1;
        if (samples_fire)
            predict_measurement(sample_bus.data);
        // register writes only happen while idle, so order against edges is safe
        if (cfg_fire)
            divider_model = cfg_bus.data.ticks_per_cm;
        if (result_fire)
        begin
            got = result_bus.data;
            if (expected_measurements.size() == 0)
                report_mismatch($sformatf("measurement with none pending, sensor %0d ticks %0d",
                                          got.sensor_id, got.echo_ticks));
            else
            begin
                want = expected_measurements.pop_front();
                if (got.sensor_id !== want.sensor_id)
                    report_mismatch($sformatf("sensor_id %0d, want %0d",
                                              got.sensor_id, want.sensor_id));
                if (got.echo_ticks !== want.echo_ticks)
                    report_mismatch($sformatf("echo_ticks %0d, want %0d",
                                              got.echo_ticks, want.echo_ticks));
                if (got.distance_cm !== want.distance_cm)
                    report_mismatch($sformatf("distance_cm %0d, want %0d (ticks %0d)",
                                              got.distance_cm, want.distance_cm,
                                              want.echo_ticks));
                if (got.average_cm !== want.average_cm)
                    report_mismatch($sformatf("average_cm %0d, want %0d",
                                              got.average_cm, want.average_cm));
                if (got.samples_held !== want.samples_held)
                    report_mismatch($sformatf("samples_held %0d, want %0d",
                                              got.samples_held, want.samples_held));
            end
        end
        // watchdog on cycles with no transaction of any kind
        if (!rst_n || samples_fire || result_fire || cfg_fire)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [STAMP_W-1:0] divider_plan [7];
        rst_n = 1'b0;
        cfg_bus.valid    = 1'b0;
        cfg_bus.data     = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed edges at the reset divider of 58
        queue_edge(3, 16'hFFFF);            // unused channel, all ones
        queue_edge(0, 16'h0000);
        queue_edge(0, 16'h0000);            // equal stamps give zero width
        queue_edge(1, 16'hFFF0);
        queue_edge(1, 16'h0010);            // fall stamp wrapped past zero
        queue_edge(2, 16'h0000);
        queue_edge(3, 16'h0000);            // unused channel between a pair
        queue_edge(2, 16'hFFFF);            // widest pulse, distance saturates
        // five more pulses on channel 0 fill the window and then slide it
        for (int d = 1; d <= 5; d++)
        begin
            queue_edge(0, 16'(d * 1000));
            queue_edge(0, 16'(d * 1000 + TICKS_RESET * d * 10));
        end
        // two channels interleaved
        queue_edge(1, 16'h1234);
        queue_edge(2, 16'h8000);
        queue_edge(1, 16'(16'h1234 + TICKS_RESET * 255));
        queue_edge(2, 16'(16'h8000 + TICKS_RESET * 256 + 16'd57));
        wait_for_idle();

        // zero divisor acts as a saturating divide
        write_divider(16'd0);
        queue_edge(0, 16'h0100);
        queue_edge(0, 16'h0101);
        queue_edge(1, 16'h0200);
        queue_edge(1, 16'h0200);
        wait_for_idle();

        // random phases across the divider range, extremes included
        divider_plan = '{16'd1, 16'hFFFF, TICKS_RESET, 16'($urandom_range(2, 40)),
                         16'd0, 16'($urandom_range(1, 65535)), 16'd300};
        for (int p = 0; p < 7; p++)
        begin
            write_divider(divider_plan[p]);
            queue_random(RANDOM_EDGES, divider_plan[p]);
            // receiver backs off while the sender keeps offering edges
            if (p == 2)
                hold_request = 1'b1;
            wait_for_idle();
        end

        if (expected_measurements.size() != 0)
            report_mismatch($sformatf("%0d measurements never arrived",
                                      expected_measurements.size()));
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[sim.f]
design/era_pkg.sv
design/era_chan_if.sv
design/era_ram.sv
design/echo_range_moving_average.sv
test/echo_range_moving_average_tb.sv
